FILE: hw/rtl/lowest_free_slot_allocator_macros.svh
// assertion macros for the slot allocator checker
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_MACROS_SVH

// implication checked on every clock edge outside reset
`define LFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsa check failed");

// next-cycle implication checked outside reset
`define LFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsa check failed");

`endif

FILE: hw/rtl/lfsa_pkg.sv
package lfsa_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE_IDX = 3'd1,
        OP_FREE_TOP = 3'd2,
        OP_RESERVE  = 3'd3,
        OP_COMPACT  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_INVALID = 2'd2,
        ST_NO_MOVE = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  slot_index;
        logic [10:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_index;
        logic [9:0]  moved_from;
        logic [10:0] end_free;
        logic [10:0] in_use_count;
        logic        last;
    } out_item_t;

    // number of tracked slots, tied to the index and count field widths
    localparam int unsigned SLOTS = 1024;

    // bit width of one map memory word, scanned as a whole
    localparam int unsigned WORD_BITS = 64;

endpackage

FILE: hw/rtl/lowest_free_slot_allocator.sv
// lowest-free slot allocator over a word-wide in-use map memory
// a map scan reads one 64-bit word at a time, for allocate, for a free of the top slot and
// for each compact step; reserve reads and rewrites each word that it spans
// compact results leave one per transfer once all moves are done
// throughput: one item at a time in the back end, front queue takes items meanwhile
// reset: async active low; map memory cleared word by word first
module lowest_free_slot_allocator #(
    parameter int unsigned MAX_MOVES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lfsa_pkg::in_item_t  in_item,
    input  logic                push,
    output logic                full,
    output lfsa_pkg::out_item_t out_item,
    output logic                empty,
    input  logic                pop
);
    import lfsa_pkg::*;

    in_item_t cmd;
    logic     cmd_valid, cmd_take, res_valid;

    // command queue decouples the port from the executing back end
    lfsa_front #(.DEPTH(4)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    // map memory, counters and the result register
    lfsa_back #(.MAX_MOVES(MAX_MOVES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .res       (out_item),
        .res_valid (res_valid),
        .res_take  (pop)
    );

    // result transfer happens when pop meets a waiting result
    assign empty = !res_valid;
endmodule

FILE: hw/rtl/lfsa_front.sv
// front: accepts items, drops undefined codes, queues the rest
module lfsa_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lfsa_pkg::in_item_t in_item,
    input  logic              push,
    output logic              full,
    output lfsa_pkg::in_item_t cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);
    import lfsa_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_item_t          mem [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr, rd, legal;

    assign legal     = (in_item.operation <= 3'(OP_COMPACT));
    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign wr        = push && !full && legal;
    assign cmd_valid = (cnt_reg != '0);
    assign rd        = cmd_valid && cmd_take;
    assign cmd       = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

FILE: hw/rtl/lfsa_back.sv
// back: executes commands over a word-organized map memory
module lfsa_back #(
    parameter int unsigned MAX_MOVES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lfsa_pkg::in_item_t cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output lfsa_pkg::out_item_t res,
    output logic               res_valid,
    input  logic               res_take
);
    import lfsa_pkg::*;

    localparam int unsigned W    = (SLOTS < WORD_BITS) ? SLOTS : WORD_BITS;
    localparam int unsigned NW   = (SLOTS + W - 1) / W;
    localparam int unsigned WA   = (NW > 1) ? $clog2(NW) : 1;
    localparam int unsigned BA   = (W > 1) ? $clog2(W) : 1;
    localparam int unsigned SW   = $clog2(SLOTS + 1);
    localparam int unsigned IW   = $clog2(SLOTS);
    localparam int unsigned MW   = $clog2(MAX_MOVES + 1);
    localparam int unsigned MA   = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIND_LO, S_FIND_HI, S_RD, S_WR,
        S_RES_RD, S_RES_WR, S_MOVE, S_EMIT, S_HOLD
    } state_t;

    logic [W-1:0] map_mem [NW];
    logic [W-1:0] rdata_reg;

    // compact moves are kept until the final map top is known
    logic [IW-1:0] mv_hole_mem [MAX_MOVES];
    logic [IW-1:0] mv_src_mem  [MAX_MOVES];

    state_t        state_reg;
    in_item_t      cmd_reg;
    logic [SW-1:0] used_reg;
    logic [IW-1:0] high_reg;
    logic [WA-1:0] wa_reg;
    logic [SW-1:0] pos_reg;      // reserve cursor / general index
    logic [SW-1:0] stop_reg;
    logic [IW-1:0] hole_reg;
    logic [MW-1:0] moves_reg;
    logic [MW-1:0] limit_reg;
    logic [MW-1:0] out_cnt_reg;  // next stored move to send
    logic          rd_pend_reg;
    logic          after_reg;    // what follows a find: 0 single op, 1 compact
    logic [1:0]    phase_reg;    // compact step within one move
    out_item_t     pend_reg;     // result being built for a single op
    out_item_t     res_reg;
    logic          res_valid_reg;

    logic          we;
    logic [WA-1:0] waddr;
    logic [W-1:0]  wdata;

    // lowest zero / highest one in the registered word
    logic [BA-1:0] lo_zero, hi_one;
    logic          has_zero, has_one;

    always_comb
    begin
        lo_zero  = '0;
        has_zero = 1'b0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (!rdata_reg[i])
            begin
                lo_zero  = BA'(i);
                has_zero = 1'b1;
            end
        end
        hi_one  = '0;
        has_one = 1'b0;
        for (int i = 0; i < W; i++)
        begin
            if (rdata_reg[i])
            begin
                hi_one  = BA'(i);
                has_one = 1'b1;
            end
        end
    end

    logic [SW-1:0] ef_now;
    assign ef_now = (used_reg == '0) ? SW'(SLOTS) : SW'(SLOTS - 1) - SW'(high_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            map_mem[waddr] <= wdata;
        end
        rdata_reg <= map_mem[wa_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR && cmd_reg.operation == 3'(OP_COMPACT) && phase_reg == 2'd0)
        begin
            mv_hole_mem[MA'(moves_reg)] <= hole_reg;
            mv_src_mem[MA'(moves_reg)]  <= IW'(pos_reg);
        end
    end

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // memory write port driven from state
    logic [BA-1:0] bitsel;
    always_comb
    begin
        we     = 1'b0;
        waddr  = wa_reg;
        wdata  = rdata_reg;
        bitsel = BA'(pos_reg);
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            wdata = '0;
        end
        else if (state_reg == S_WR)
        begin
            we = 1'b1;
            wdata[bitsel] = (cmd_reg.operation == 3'(OP_ALLOC)) ||
                (cmd_reg.operation == 3'(OP_COMPACT) && phase_reg == 2'd1);
        end
        else if (state_reg == S_RES_WR)
        begin
            we = 1'b1;
            for (int i = 0; i < W; i++)
            begin
                if (SW'(wa_reg) * SW'(W) + SW'(i) >= pos_reg &&
                    SW'(wa_reg) * SW'(W) + SW'(i) < stop_reg)
                begin
                    wdata[i] = 1'b1;
                end
            end
        end
    end

    function automatic out_item_t mk(input logic [1:0] st, input logic [9:0] ri,
                                     input logic [9:0] mf, input logic lst);
        out_item_t r;
        r.status       = st;
        r.result_index = ri;
        r.moved_from   = mf;
        r.end_free     = '0;
        r.in_use_count = '0;
        r.last         = lst;
        return r;
    endfunction

    // fills in the map summary taken after the whole command
    function automatic out_item_t with_tail(input out_item_t p, input logic [SW-1:0] ef,
                                            input logic [SW-1:0] cnt);
        out_item_t r;
        r              = p;
        r.end_free     = 11'(ef);
        r.in_use_count = 11'(cnt);
        return r;
    endfunction

    logic [SW-1:0] found;
    logic [SW-1:0] amt_sw;
    logic [SW-1:0] start_sw;
    assign found    = SW'(wa_reg) * SW'(W) + SW'(lo_zero);
    assign amt_sw   = (cmd.amount > 11'(SLOTS)) ? SW'(SLOTS) + 1'b1 : SW'(cmd.amount);
    assign start_sw = (used_reg == '0) ? '0 : SW'(high_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            used_reg      <= '0;
            high_reg      <= '0;
            wa_reg        <= '0;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            phase_reg     <= '0;
            moves_reg     <= '0;
            limit_reg     <= '0;
            out_cnt_reg   <= '0;
            after_reg     <= 1'b0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            hole_reg      <= '0;
            cmd_reg       <= '0;
            pend_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    wa_reg <= wa_reg + 1'b1;
                    if (wa_reg == WA'(NW - 1))
                    begin
                        wa_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    rd_pend_reg <= 1'b1;
                    wa_reg      <= '0;
                    phase_reg   <= '0;
                    moves_reg   <= '0;
                    out_cnt_reg <= '0;
                    if (cmd_valid)
                    begin
                        cmd_reg <= cmd;
                        case (cmd.operation)
                            3'(OP_ALLOC):
                            begin
                                after_reg <= 1'b0;
                                state_reg <= S_FIND_LO;
                            end
                            3'(OP_FREE_IDX):
                            begin
                                pos_reg   <= SW'(cmd.slot_index);
                                wa_reg    <= WA'(SW'(cmd.slot_index) >> BA);
                                state_reg <= (SW'(cmd.slot_index) >= SW'(SLOTS)) ? S_EMIT : S_RD;
                                pend_reg  <= mk(ST_INVALID, cmd.slot_index, '0, 1'b1);
                            end
                            3'(OP_FREE_TOP):
                            begin
                                pos_reg   <= SW'(high_reg);
                                wa_reg    <= WA'(SW'(high_reg) >> BA);
                                pend_reg  <= mk(ST_INVALID, '0, '0, 1'b1);
                                state_reg <= (used_reg == '0) ? S_EMIT : S_RD;
                            end
                            3'(OP_RESERVE):
                            begin
                                pos_reg   <= start_sw;
                                stop_reg  <= start_sw + amt_sw;
                                wa_reg    <= WA'(start_sw >> BA);
                                if (cmd.amount == '0)
                                begin
                                    pend_reg  <= mk(ST_OK, '0, '0, 1'b1);
                                    state_reg <= S_EMIT;
                                end
                                else if (amt_sw > SW'(SLOTS) - start_sw)
                                begin
                                    pend_reg  <= mk(ST_NO_ROOM, '0, '0, 1'b1);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    pend_reg  <= mk(ST_OK, 10'(start_sw), '0, 1'b1);
                                    state_reg <= S_RES_RD;
                                end
                            end
                            default:
                            begin
                                limit_reg <= (cmd.amount < 11'(MAX_MOVES)) ?
                                    MW'(cmd.amount) : MW'(MAX_MOVES);
                                after_reg <= 1'b1;
                                state_reg <= S_MOVE;
                            end
                        endcase
                    end
                end
                S_FIND_LO:
                begin
                    // rdata is registered, valid in the cycle after the address
                    if (rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    else if (has_zero && (found < SW'(SLOTS)))
                    begin
                        if (after_reg)
                        begin
                            hole_reg  <= IW'(found);
                            if (found >= SW'(high_reg))
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                phase_reg   <= 2'd0;
                                pos_reg     <= SW'(high_reg);
                                wa_reg      <= WA'(SW'(high_reg) >> BA);
                                rd_pend_reg <= 1'b1;
                                state_reg   <= S_RD;
                            end
                        end
                        else
                        begin
                            pos_reg     <= found;
                            pend_reg    <= mk(ST_OK, 10'(found), '0, 1'b1);
                            rd_pend_reg <= 1'b1;
                            state_reg   <= S_RD;
                        end
                    end
                    else if (wa_reg == WA'(NW - 1))
                    begin
                        if (after_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            pend_reg  <= mk(ST_NO_ROOM, '0, '0, 1'b1);
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        wa_reg      <= wa_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_FIND_HI:
                begin
                    if (rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    else if (has_one)
                    begin
                        high_reg  <= IW'(SW'(wa_reg) * SW'(W) + SW'(hi_one));
                        state_reg <= (after_reg && phase_reg == 2'd1) ? S_RD : S_EMIT;
                        if (after_reg && phase_reg == 2'd1)
                        begin
                            pos_reg     <= SW'(hole_reg);
                            wa_reg      <= WA'(SW'(hole_reg) >> BA);
                            rd_pend_reg <= 1'b1;
                        end
                    end
                    else if (wa_reg == '0)
                    begin
                        high_reg  <= '0;
                        state_reg <= (after_reg && phase_reg == 2'd1) ? S_RD : S_EMIT;
                        if (after_reg && phase_reg == 2'd1)
                        begin
                            pos_reg     <= SW'(hole_reg);
                            wa_reg      <= WA'(SW'(hole_reg) >> BA);
                            rd_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wa_reg      <= wa_reg - 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_RD:
                begin
                    if (rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    else if (cmd_reg.operation == 3'(OP_FREE_IDX) && !rdata_reg[bitsel])
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    if (cmd_reg.operation == 3'(OP_ALLOC) ||
                        (cmd_reg.operation == 3'(OP_COMPACT) && phase_reg == 2'd1))
                    begin
                        // set a bit
                        if (used_reg == '0 || IW'(pos_reg) > high_reg)
                        begin
                            high_reg <= IW'(pos_reg);
                        end
                        used_reg  <= used_reg + 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // clear a bit, then rescan from it downward if it was the top
                        used_reg <= used_reg - 1'b1;
                        if (cmd_reg.operation != 3'(OP_COMPACT))
                        begin
                            pend_reg <= mk(ST_OK, 10'(pos_reg), '0, 1'b1);
                        end
                        else
                        begin
                            phase_reg <= 2'd1;
                        end
                        if (IW'(pos_reg) == high_reg && used_reg != SW'(1))
                        begin
                            rd_pend_reg <= 1'b1;
                            state_reg   <= S_FIND_HI;
                        end
                        else
                        begin
                            if (used_reg == SW'(1))
                            begin
                                high_reg <= '0;
                            end
                            if (cmd_reg.operation == 3'(OP_COMPACT))
                            begin
                                pos_reg     <= SW'(hole_reg);
                                wa_reg      <= WA'(SW'(hole_reg) >> BA);
                                rd_pend_reg <= 1'b1;
                                state_reg   <= S_RD;
                            end
                            else
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                    end
                end
                S_RES_RD:
                begin
                    rd_pend_reg <= 1'b0;
                    if (!rd_pend_reg)
                    begin
                        state_reg <= S_RES_WR;
                    end
                end
                S_RES_WR:
                begin
                    if ((SW'(wa_reg) + 1'b1) * SW'(W) >= stop_reg)
                    begin
                        used_reg  <= used_reg + (stop_reg - pos_reg);
                        high_reg  <= IW'(stop_reg - 1'b1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        wa_reg      <= wa_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                        state_reg   <= S_RES_RD;
                    end
                end
                S_MOVE:
                begin
                    // start one compact move: find the lowest hole
                    if (moves_reg == limit_reg || used_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        phase_reg   <= '0;
                        wa_reg      <= '0;
                        rd_pend_reg <= 1'b1;
                        state_reg   <= S_FIND_LO;
                    end
                end
                S_EMIT:
                begin
                    if (cmd_reg.operation == 3'(OP_COMPACT) && phase_reg == 2'd1)
                    begin
                        // one move done, look for another
                        phase_reg <= 2'd2;
                        moves_reg <= moves_reg + 1'b1;
                        state_reg <= S_HOLD;
                    end
                    else if (cmd_reg.operation == 3'(OP_COMPACT) && moves_reg == '0)
                    begin
                        if (!res_valid_reg || res_take)
                        begin
                            res_reg       <= with_tail(mk(ST_NO_MOVE, '0, '0, 1'b1),
                                                       ef_now, used_reg);
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (cmd_reg.operation == 3'(OP_COMPACT))
                    begin
                        // no further move: send the stored moves
                        state_reg <= S_HOLD;
                        phase_reg <= 2'd3;
                    end
                    else if (!res_valid_reg || res_take)
                    begin
                        res_reg       <= with_tail(pend_reg, ef_now, used_reg);
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    // S_HOLD: phase 2 tries another move first, phase 3 sends stored moves
                    if (phase_reg == 2'd2)
                    begin
                        if (moves_reg == limit_reg || used_reg == '0)
                        begin
                            phase_reg <= 2'd3;
                        end
                        else
                        begin
                            phase_reg   <= 2'd0;
                            wa_reg      <= '0;
                            rd_pend_reg <= 1'b1;
                            state_reg   <= S_FIND_LO;
                        end
                    end
                    else if (!res_valid_reg || res_take)
                    begin
                        res_reg <= with_tail(mk(ST_OK, mv_hole_mem[MA'(out_cnt_reg)],
                                                mv_src_mem[MA'(out_cnt_reg)],
                                                out_cnt_reg == moves_reg - 1'b1),
                                             ef_now, used_reg);
                        res_valid_reg <= 1'b1;
                        if (out_cnt_reg == moves_reg - 1'b1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_cnt_reg <= out_cnt_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end
endmodule

FILE: hw/rtl/lfsa_checker.sv
`include "lowest_free_slot_allocator_macros.svh"
module lfsa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input lfsa_pkg::out_item_t out_item
);
    import lfsa_pkg::*;
    `LFSA_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))
    `LFSA_ASSERT_IMPL(a_moved, clk, rst_n, !empty && out_item.status != ST_OK, out_item.moved_from == '0)
    `LFSA_ASSERT_IMPL(a_cnt, clk, rst_n, !empty && out_item.in_use_count == '0, out_item.end_free == 11'(SLOTS))
endmodule

bind lowest_free_slot_allocator lfsa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_item(out_item)
);
